// ===== hdl/ordered_list_insert_delete_search_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list core
// Concurrent checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_CORE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define OLIDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define OLIDS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define OLIDS_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define OLIDS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/olids_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list core package
// Transfer types, operation and status codes, cell control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olids_pkg;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_SEARCH = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BADPOS   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] value;
		logic [7:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [6:0]         found_index;
		logic signed [31:0] removed_value;
		logic [7:0]         count_after;
	} rsp_t;

	typedef struct packed {
		logic               ins;
		logic               del;
		logic               srch;
		logic               walk;
		logic signed [31:0] value;
	} ctl_t;

endpackage

`default_nettype wire

// ===== hdl/olids_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one entry plus a readout word and flag that walk towards cell 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olids_cell
	import olids_pkg::*;
#(
	parameter int IDX = 0,
	parameter int PW  = 8,
	parameter int CW  = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ctl_t                ctl,
	input  wire [PW-1:0]        pos,
	input  wire [CW-1:0]        count,
	input  wire signed [31:0]   data_below,
	input  wire signed [31:0]   data_above,
	input  wire signed [31:0]   rd_above,
	input  wire                 hit_above,
	output logic signed [31:0]  data,
	output logic signed [31:0]  rd,
	output logic                hit
);

	logic signed [31:0] data_q;
	logic signed [31:0] rd_q;
	logic               hit_q;
	logic               pos_eq;
	logic               pos_lt;
	logic               live;

	assign pos_eq = pos == PW'(IDX);
	assign pos_lt = pos < PW'(IDX);
	assign live   = CW'(IDX) < count;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (pos_lt) begin
				data_q <= data_below;
			end else if (pos_eq) begin
				data_q <= ctl.value;
			end
		end else if (ctl.del) begin
			if (pos_lt || pos_eq) begin
				data_q <= data_above;
			end
		end
		if (ctl.del) begin
			rd_q <= data_q;
		end else if (ctl.walk) begin
			rd_q <= rd_above;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.del) begin
			hit_q <= pos_eq;
		end else if (ctl.srch) begin
			hit_q <= live && (data_q == ctl.value);
		end else if (ctl.walk) begin
			hit_q <= hit_above;
		end
	end

	assign data = data_q;
	assign rd   = rd_q;
	assign hit  = hit_q;

endmodule

`default_nettype wire

// ===== hdl/ordered_list_insert_delete_search_core.sv =====
// ----------------------------------------------------------------------------
// Ordered list core with insert, delete and linear search
// A row of DEPTH cells shifts all entries at once on insert and delete;
// lookups walk a flag and a readout word down the row to cell 0.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req   (mode, value, position)
//  rsp     | out       | rsp_valid/rsp_stall | rsp   (status, found_index,
//          |           |                     |        removed_value, count_after)
//
//  Insert, failed operations and mode 3 go from transfer straight to the result.
//  Delete and search first walk the cell row: delete until the marked entry reaches
//  cell 0, search until a hit reaches cell 0 or all live entries are passed.
//  One item at a time; the next request is taken once the result is queued.
//  Reset empties the list; entries are not cleared and need no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_list_insert_delete_search_core_macros.svh"

module ordered_list_insert_delete_search_core
	import olids_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   req_valid,
	output logic  req_stall,
	input  req_t  req,
	output logic  rsp_valid,
	input  wire   rsp_stall,
	output rsp_t  rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 8) ? CW : 8;

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  steps_q;
	logic [1:0]     op_q;
	rsp_t           res_q;
	rsp_t           rsp_q;
	logic           rsp_valid_q;

	logic           acc;
	logic [PW-1:0]  pos_ext;
	logic [PW-1:0]  cnt_ext;
	logic           is_full;
	logic           is_empty;
	logic           ins_bad;
	logic           del_bad;
	logic [CW-1:0]  count_nxt;
	logic [2:0]     status_imm;
	ctl_t           ctl;

	logic signed [31:0] data_w  [DEPTH];
	logic signed [31:0] rd_w    [DEPTH];
	logic [DEPTH-1:0]   hit_vec;

	assign acc      = req_valid && (state_q == S_IDLE);
	assign pos_ext  = PW'(req.position);
	assign cnt_ext  = PW'(count_q);
	assign is_full  = count_q == CW'(DEPTH);
	assign is_empty = count_q == '0;
	assign ins_bad  = pos_ext > cnt_ext;
	assign del_bad  = !(pos_ext < cnt_ext);

	assign ctl.ins   = acc && (req.mode == MODE_INSERT) && !is_full && !ins_bad;
	assign ctl.del   = acc && (req.mode == MODE_DELETE) && !is_empty && !del_bad;
	assign ctl.srch  = acc && (req.mode == MODE_SEARCH) && !is_empty;
	assign ctl.walk  = state_q == S_WALK;
	assign ctl.value = req.value;

	always_comb begin
		count_nxt = count_q;
		if (ctl.ins) begin
			count_nxt = count_q + CW'(1);
		end else if (ctl.del) begin
			count_nxt = count_q - CW'(1);
		end
	end

	always_comb begin
		case (req.mode)
			MODE_INSERT: begin
				if (is_full) begin
					status_imm = ST_FULL;
				end else if (ins_bad) begin
					status_imm = ST_BADPOS;
				end else begin
					status_imm = ST_OK;
				end
			end
			MODE_DELETE: begin
				if (is_empty) begin
					status_imm = ST_EMPTY;
				end else if (del_bad) begin
					status_imm = ST_BADPOS;
				end else begin
					status_imm = ST_OK;
				end
			end
			MODE_SEARCH: status_imm = ST_NOTFOUND;
			default:     status_imm = ST_OK;
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] below_w;
		logic signed [31:0] above_w;
		logic signed [31:0] rd_above_w;
		logic               hit_above_w;

		if (i == 0) begin : g_first
			assign below_w = '0;
		end else begin : g_mid
			assign below_w = data_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign above_w     = '0;
			assign rd_above_w  = '0;
			assign hit_above_w = 1'b0;
		end else begin : g_body
			assign above_w     = data_w[i+1];
			assign rd_above_w  = rd_w[i+1];
			assign hit_above_w = hit_vec[i+1];
		end

		olids_cell #(
			.IDX (i),
			.PW  (PW),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.pos        (pos_ext),
			.count      (count_q),
			.data_below (below_w),
			.data_above (above_w),
			.rd_above   (rd_above_w),
			.hit_above  (hit_above_w),
			.data       (data_w[i]),
			.rd         (rd_w[i]),
			.hit        (hit_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			steps_q     <= '0;
			op_q        <= MODE_INSERT;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						count_q                 <= count_nxt;
						op_q                    <= req.mode;
						steps_q                 <= '0;
						res_q.status            <= status_imm;
						res_q.found_index       <= '0;
						res_q.removed_value     <= '0;
						res_q.count_after       <= 8'(count_nxt);
						state_q                 <= (ctl.del || ctl.srch) ? S_WALK : S_FIN;
					end
				end
				S_WALK: begin
					if (hit_vec[0]) begin
						if (op_q == MODE_DELETE) begin
							res_q.removed_value <= rd_w[0];
						end else begin
							res_q.status      <= ST_OK;
							res_q.found_index <= 7'(steps_q);
						end
						state_q <= S_FIN;
					end else if ((op_q == MODE_SEARCH) && (steps_q == count_q - CW'(1))) begin
						state_q <= S_FIN;
					end else begin
						steps_q <= steps_q + CW'(1);
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`OLIDS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`OLIDS_ASSERT_NXT(a_transfer_leaves_idle, clk, arst_n, req_valid && !req_stall, state_q != S_IDLE)
	`OLIDS_ASSERT_IMP(a_delete_single_mark, clk, arst_n, (state_q == S_WALK) && (op_q == MODE_DELETE), $onehot0(hit_vec))
	`OLIDS_ASSERT_IMP(a_walk_in_range, clk, arst_n, state_q == S_WALK, steps_q <= count_q)

endmodule

`default_nettype wire

// ===== dv/olids_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list checker
// Watches both channels of the ordered list core. It applies each accepted
// request to its own copy of the list and count, and queues the expected
// response. Each accepted response is compared field by field with the
// oldest queued one. It counts failures for the top.
// ----------------------------------------------------------------------------

module olids_checker
	import olids_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fail_count,
	output int   waiting
);

	logic signed [31:0] list_q [DEPTH];
	int                 held;
	rsp_t               expected_q [$];

	initial begin
		fail_count = 0;
		waiting    = 0;
		held       = 0;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic rsp_t apply_op(input req_t op);
		rsp_t o;
		int   i;
		o = '0;
		case (op.mode)
			MODE_INSERT: begin
				if (held >= DEPTH) begin
					o.status = ST_FULL;
				end else if (op.position > held) begin
					o.status = ST_BADPOS;
				end else begin
					for (i = held; i > op.position; i--)
						list_q[i] = list_q[i - 1];
					list_q[op.position] = op.value;
					held++;
				end
			end
			MODE_DELETE: begin
				if (held == 0) begin
					o.status = ST_EMPTY;
				end else if (op.position >= held) begin
					o.status = ST_BADPOS;
				end else begin
					o.removed_value = list_q[op.position];
					for (i = op.position; i + 1 < held; i++)
						list_q[i] = list_q[i + 1];
					held--;
				end
			end
			MODE_SEARCH: begin
				o.status = ST_NOTFOUND;
				for (i = 0; i < held; i++) begin
					if (list_q[i] == op.value) begin
						o.status      = ST_OK;
						o.found_index = i[6:0];
						break;
					end
				end
			end
			default: ;
		endcase
		o.count_after = held[7:0];
		return o;
	endfunction

	always @(posedge clk) begin : watch
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected response", {3'd0, rsp.status, 26'd0},
						32'd0);
				end else begin
					want = expected_q.pop_front();
					if (rsp.status !== want.status)
						report("status", rsp.status, want.status);
					if (rsp.found_index !== want.found_index)
						report("found_index", rsp.found_index, want.found_index);
					if (rsp.removed_value !== want.removed_value)
						report("removed_value", rsp.removed_value, want.removed_value);
					if (rsp.count_after !== want.count_after)
						report("count_after", rsp.count_after, want.count_after);
				end
			end
			if (req_valid && !req_stall)
				expected_q.push_back(apply_op(req));
			waiting = expected_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list core testbench
// Drives a short directed run through every operation and the empty, bad position
// and not found cases, then random fill and drain phases that take the list from
// empty to full and back, with searches and stray requests mixed in. Both channels
// idle at random. The checker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------

module tb;
	import olids_pkg::*;

	localparam int DEPTH = 128;
	localparam int N_RANDOM = 1250;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int fail_count;
	int waiting;
	int held      = 0;
	int rsp_hold  = 0;
	bit quiet     = 1'b0;

	always #5 clk = ~clk;

	ordered_list_insert_delete_search_core #(.DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	olids_checker #(.DEPTH(DEPTH)) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.waiting    (waiting)
	);

	function automatic int draw_idle();
		return quiet ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return -32'sd1;
			3, 4, 5: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// hold the response side off for a drawn number of cycles after each transfer
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			rsp_hold <= draw_idle();
		else if (rsp_hold != 0)
			rsp_hold <= rsp_hold - 1;
	end

	always @(negedge clk)
		rsp_stall <= (rsp_hold != 0);

	task automatic issue(input logic [1:0] mode, input logic signed [31:0] value,
		input logic [7:0] position);
		req_t item;
		int   gap;
		item.mode     = mode;
		item.value    = value;
		item.position = position;
		gap = draw_idle();
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		case (mode)
			MODE_INSERT: if (held < DEPTH && position <= held) held++;
			MODE_DELETE: if (held != 0 && position < held) held--;
			default: ;
		endcase
	endtask

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int         extreme;
		bit         filling;
		int         r;
		bit         is_ins;
		logic [1:0] m;
		logic [7:0] p;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		issue(MODE_SEARCH, 32'sd0, 8'd0);
		issue(MODE_DELETE, 32'sd5, 8'd0);
		issue(MODE_DELETE, 32'sd5, 8'd200);
		issue(MODE_INSERT, 32'sd7, 8'd1);
		issue(MODE_INSERT, 32'sh7fffffff, 8'd0);
		issue(MODE_INSERT, 32'sh80000000, 8'd1);
		issue(MODE_INSERT, 32'sd0, 8'd0);
		issue(MODE_INSERT, -32'sd1, 8'd1);
		issue(MODE_INSERT, -32'sd1, 8'd2);
		issue(MODE_SEARCH, -32'sd1, 8'd0);
		issue(MODE_SEARCH, 32'sh80000000, 8'd0);
		issue(MODE_SEARCH, 32'sd12345, 8'd0);
		issue(2'd3, $urandom, 8'd255);
		issue(MODE_INSERT, 32'sd9, 8'd255);
		issue(MODE_INSERT, 32'sd9, 8'd6);
		issue(MODE_DELETE, 32'sd0, 8'd5);
		issue(MODE_DELETE, 32'sd0, 8'd255);
		issue(MODE_DELETE, 32'sd0, 8'd4);
		issue(MODE_DELETE, 32'sd0, 8'd0);
		issue(MODE_SEARCH, 32'sd0, 8'd0);
		issue(MODE_DELETE, $urandom, 8'd1);
		issue(MODE_SEARCH, 32'sh7fffffff, 8'd255);

		// alternate fill and drain so the list keeps reaching full and empty
		filling = 1'b1;
		extreme = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 100 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (filling && held == DEPTH && ++extreme > 4) begin
				filling = 1'b0;
				extreme = 0;
			end
			if (!filling && held == 0 && ++extreme > 3) begin
				filling = 1'b1;
				extreme = 0;
			end
			r = $urandom_range(0, 99);
			if (r < 4) begin
				m = 2'($urandom_range(0, 3));
				issue(m, $urandom, 8'($urandom_range(0, 255)));
			end else if (r < 24) begin
				issue(MODE_SEARCH, pick_value(), 8'($urandom_range(0, 255)));
			end else begin
				is_ins = filling ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 2);
				if ($urandom_range(0, 9) == 0)
					p = 8'($urandom_range(0, 255));
				else if (is_ins)
					p = 8'($urandom_range(0, held));
				else
					p = (held != 0) ? 8'($urandom_range(0, held - 1)) : 8'd0;
				issue(is_ins ? MODE_INSERT : MODE_DELETE,
					is_ins ? pick_value() : $urandom, p);
			end
		end

		@(negedge clk);
		req_valid <= 1'b0;
		wait (waiting == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
